>>> design/tdmh_pkg.sv
// ----------------------------------------------------------------------------
// tdmh_pkg
// shared types and constants for the timer deadline min-heap
// ----------------------------------------------------------------------------
package tdmh_pkg;

    localparam int MAX_TIMERS  = 256;
    localparam int NUM_HANDLES = 256;
    localparam int HEAP_CAP    = (MAX_TIMERS < NUM_HANDLES) ? MAX_TIMERS : NUM_HANDLES;

    localparam int IN_BITS  = 74;
    localparam int OUT_BITS = 85;
    localparam int IN_W     = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

    typedef enum logic [1:0] {
        REQ_ADD    = 2'd0,
        REQ_REMOVE = 2'd1,
        REQ_POP    = 2'd2,
        REQ_NONE   = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        STS_OK       = 2'd0,
        STS_FULL     = 2'd1,
        STS_EMPTY    = 2'd2,
        STS_BAD_HNDL = 2'd3
    } status_t;

    typedef struct packed {
        logic        [7:0]  handle;
        logic signed [63:0] deadline;
    } entry_t;

    // strictly later in signed time
    function automatic logic is_later(input logic signed [63:0] a,
                                      input logic signed [63:0] b);
        return a > b;
    endfunction

endpackage

>>> design/timer_deadline_min_heap_top.sv
// ----------------------------------------------------------------------------
// timer_deadline_min_heap_top
// indexed binary min-heap of timer handles keyed by signed deadline
// ----------------------------------------------------------------------------
//  channel   dir  ports                          beat contents (lsb first)
//  request   in   s_tvalid s_tready s_tdata[79:0] req_type, timer_id, deadline
//  result    out  m_tvalid m_tready m_tdata[87:0] status, became_top, is_empty,
//                                                 top_id, top_deadline, count
//
//  one request at a time; a beat runs longer with every sift-up or
//  sift-down level it walks, paced by the single read port of the heap
//  memory: one slot read a cycle
//  aresetn (sync, active low) clears control and the count only; memories
//  need no clearing, an unwritten slot is never read below the count
//  a new request beat is taken while a result beat still waits on m_tready
// ----------------------------------------------------------------------------
module timer_deadline_min_heap_top (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    // req_type[1:0], timer_id[9:2], deadline[73:10], zero pad
    input  logic [tdmh_pkg::IN_W-1:0]  s_tdata,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    // status[1:0], became_top[2], is_empty[3], top_id[11:4],
    // top_deadline[75:12], count[84:76], zero pad
    output logic [tdmh_pkg::OUT_W-1:0] m_tdata
);
    import tdmh_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE, ST_CHK1, ST_CHK2, ST_REM, ST_REM2, ST_UP_RD, ST_UP_CMP,
        ST_DN_RD, ST_DN_L, ST_DN_R, ST_DN_CMP, ST_TOP, ST_OUT
    } state_t;

    // heap slots and handle-to-slot map
    entry_t     heap_mem [HEAP_CAP];
    logic [7:0] pos_mem  [NUM_HANDLES];

    entry_t     heap_rd;
    logic [7:0] pos_rd;
    logic       heap_we;
    logic [7:0] heap_waddr, heap_raddr;
    entry_t     heap_wdata;
    logic       pos_we;
    logic [7:0] pos_waddr, pos_raddr, pos_wdata;

    state_t      state_reg, state_next;
    req_t        req_reg, req_next;
    logic [7:0]  id_reg, id_next;
    logic signed [63:0] dl_reg, dl_next;
    logic [8:0]  count_reg, count_next;
    logic [7:0]  hole_reg, hole_next;
    logic [7:0]  idx_reg, idx_next;
    entry_t      cur_reg, cur_next;
    entry_t      left_reg, left_next;
    entry_t      right_reg, right_next;
    logic        has_r_reg, has_r_next;
    logic        first_reg, first_next;
    status_t     sts_reg, sts_next;
    logic        top_reg, top_next;
    logic        m_tvalid_reg, m_tvalid_next;
    logic [OUT_W-1:0] m_tdata_reg, m_tdata_next;

    logic [9:0] l_w, r_w;
    logic       held;
    logic       pick_r;
    entry_t     child;
    logic       cur_gt_child;
    logic [8:0] last_w;

    assign l_w    = {1'b0, idx_reg, 1'b1};
    assign r_w    = l_w + 10'd1;
    assign held   = ({1'b0, hole_reg} < count_reg) && (heap_rd.handle == id_reg);
    assign pick_r = has_r_reg && is_later(left_reg.deadline, right_reg.deadline);
    assign child  = pick_r ? right_reg : left_reg;
    assign cur_gt_child = pick_r ? is_later(cur_reg.deadline, right_reg.deadline)
                                 : is_later(cur_reg.deadline, left_reg.deadline);
    assign last_w = count_reg - 9'd1;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // memories: one write and one registered read each per cycle
    always_ff @(posedge aclk) begin
        if (heap_we) begin
            heap_mem[heap_waddr] <= heap_wdata;
        end
        heap_rd <= heap_mem[heap_raddr];
    end

    always_ff @(posedge aclk) begin
        if (pos_we) begin
            pos_mem[pos_waddr] <= pos_wdata;
        end
        pos_rd <= pos_mem[pos_raddr];
    end

    always_comb begin
        state_next    = state_reg;
        req_next      = req_reg;
        id_next       = id_reg;
        dl_next       = dl_reg;
        count_next    = count_reg;
        hole_next     = hole_reg;
        idx_next      = idx_reg;
        cur_next      = cur_reg;
        left_next     = left_reg;
        right_next    = right_reg;
        has_r_next    = has_r_reg;
        first_next    = first_reg;
        sts_next      = sts_reg;
        top_next      = top_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        heap_we       = 1'b0;
        heap_waddr    = idx_reg;
        heap_wdata    = cur_reg;
        heap_raddr    = 8'd0;
        pos_we        = 1'b0;
        pos_waddr     = cur_reg.handle;
        pos_wdata     = idx_reg;
        pos_raddr     = s_tdata[9:2];

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    req_next   = req_t'(s_tdata[1:0]);
                    id_next    = s_tdata[9:2];
                    dl_next    = s_tdata[73:10];
                    sts_next   = STS_OK;
                    top_next   = 1'b0;
                    state_next = ST_CHK1;
                end
            end
            ST_CHK1: begin
                hole_next  = pos_rd;
                heap_raddr = pos_rd;
                state_next = ST_CHK2;
            end
            ST_CHK2: begin
                state_next = ST_TOP;
                case (req_reg)
                    REQ_ADD: begin
                        if (held) begin
                            sts_next = STS_BAD_HNDL;
                        end else if (count_reg >= 9'(HEAP_CAP)) begin
                            sts_next = STS_FULL;
                        end else begin
                            cur_next   = '{handle: id_reg, deadline: dl_reg};
                            idx_next   = count_reg[7:0];
                            count_next = count_reg + 9'd1;
                            first_next = 1'b0;
                            state_next = ST_UP_RD;
                        end
                    end
                    REQ_REMOVE: begin
                        if (!held) begin
                            sts_next = STS_BAD_HNDL;
                        end else begin
                            state_next = ST_REM;
                        end
                    end
                    REQ_POP: begin
                        if (count_reg == 9'd0) begin
                            sts_next = STS_EMPTY;
                        end else begin
                            hole_next  = 8'd0;
                            state_next = ST_REM;
                        end
                    end
                    default: begin
                        state_next = ST_TOP;
                    end
                endcase
            end
            ST_REM: begin
                count_next = last_w;
                heap_raddr = last_w[7:0];
                state_next = ({1'b0, hole_reg} == last_w) ? ST_TOP : ST_REM2;
            end
            ST_REM2: begin
                cur_next   = heap_rd;
                idx_next   = hole_reg;
                first_next = 1'b1;
                state_next = ST_UP_RD;
            end
            ST_UP_RD: begin
                heap_raddr = 8'((idx_reg - 8'd1) >> 1);
                if (idx_reg == 8'd0) begin
                    if (first_reg) begin
                        state_next = ST_DN_RD;
                    end else begin
                        heap_we    = 1'b1;
                        pos_we     = 1'b1;
                        top_next   = (req_reg == REQ_ADD);
                        state_next = ST_TOP;
                    end
                end else begin
                    state_next = ST_UP_CMP;
                end
            end
            ST_UP_CMP: begin
                if (is_later(heap_rd.deadline, cur_reg.deadline)) begin
                    heap_we    = 1'b1;
                    heap_wdata = heap_rd;
                    pos_we     = 1'b1;
                    pos_waddr  = heap_rd.handle;
                    idx_next   = 8'((idx_reg - 8'd1) >> 1);
                    first_next = 1'b0;
                    state_next = ST_UP_RD;
                end else if (first_reg) begin
                    state_next = ST_DN_RD;
                end else begin
                    heap_we    = 1'b1;
                    pos_we     = 1'b1;
                    state_next = ST_TOP;
                end
            end
            ST_DN_RD: begin
                heap_raddr = l_w[7:0];
                if (l_w >= {1'b0, count_reg}) begin
                    heap_we    = 1'b1;
                    pos_we     = 1'b1;
                    state_next = ST_TOP;
                end else begin
                    state_next = ST_DN_L;
                end
            end
            ST_DN_L: begin
                left_next  = heap_rd;
                heap_raddr = r_w[7:0];
                if (r_w < {1'b0, count_reg}) begin
                    state_next = ST_DN_R;
                end else begin
                    has_r_next = 1'b0;
                    state_next = ST_DN_CMP;
                end
            end
            ST_DN_R: begin
                right_next = heap_rd;
                has_r_next = 1'b1;
                state_next = ST_DN_CMP;
            end
            ST_DN_CMP: begin
                if (cur_gt_child) begin
                    heap_we    = 1'b1;
                    heap_wdata = child;
                    pos_we     = 1'b1;
                    pos_waddr  = child.handle;
                    idx_next   = pick_r ? r_w[7:0] : l_w[7:0];
                    state_next = ST_DN_RD;
                end else begin
                    heap_we    = 1'b1;
                    pos_we     = 1'b1;
                    state_next = ST_TOP;
                end
            end
            ST_TOP: begin
                heap_raddr = 8'd0;
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = '0;
                    m_tdata_next[1:0]   = sts_reg;
                    m_tdata_next[2]     = top_reg;
                    m_tdata_next[3]     = (count_reg == 9'd0);
                    m_tdata_next[11:4]  = (count_reg == 9'd0) ? 8'd0 : heap_rd.handle;
                    m_tdata_next[75:12] = (count_reg == 9'd0) ? 64'd0 : heap_rd.deadline;
                    m_tdata_next[84:76] = count_reg;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        req_reg     <= req_next;
        id_reg      <= id_next;
        dl_reg      <= dl_next;
        hole_reg    <= hole_next;
        idx_reg     <= idx_next;
        cur_reg     <= cur_next;
        left_reg    <= left_next;
        right_reg   <= right_next;
        has_r_reg   <= has_r_next;
        first_reg   <= first_next;
        sts_reg     <= sts_next;
        top_reg     <= top_next;
        m_tdata_reg <= m_tdata_next;
    end

    // count never exceeds capacity
    a_count_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= 9'(HEAP_CAP))
        else $error("count above capacity");

    // no memory write while waiting for a request
    a_no_idle_write: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> !(heap_we || pos_we))
        else $error("memory write while idle");

    // a result beat appears only out of the output state
    a_result_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> $past(state_reg == ST_OUT))
        else $error("result raised outside output state");

    // count changes only as the request enters sift-up, the second remove step or the top read
    a_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        !$stable(count_reg) |-> (state_reg == ST_UP_RD || state_reg == ST_REM2
                                 || state_reg == ST_TOP))
        else $error("unexpected count change");

endmodule

>>> verif/timer_deadline_min_heap_top_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// timer_deadline_min_heap_top_test
// self-checking bench for the indexed timer min-heap
// ----------------------------------------------------------------------------
// requests go in as stream beats: adds, removes, pops and the no-op kind
// a heap tracker class mirrors the heap in software and predicts each
// result beat; every result beat is compared field by field in order
// ----------------------------------------------------------------------------
module timer_deadline_min_heap_top_test;
    import tdmh_pkg::*;

    typedef struct {
        status_t            status;
        logic               became_top;
        logic               is_empty;
        logic [7:0]         top_id;
        logic signed [63:0] top_deadline;
        logic [8:0]         count;
    } heap_result_t;

    // software copy of the heap, predicts the result of each request
    class heap_tracker;
        logic signed [63:0] dl_at [HEAP_CAP];
        logic [7:0]         id_at [HEAP_CAP];
        int                 slot_of [NUM_HANDLES];
        int                 held_count;
        heap_result_t       pending_results [$];
        int                 mismatches;
        int                 results_seen;

        function new();
            held_count = 0;
            mismatches = 0;
            results_seen = 0;
            foreach (slot_of[i]) slot_of[i] = 0;
            foreach (id_at[i]) begin
                id_at[i] = 0;
                dl_at[i] = 0;
            end
        endfunction

        function void put(int i, logic [7:0] h, logic signed [63:0] d);
            id_at[i] = h;
            dl_at[i] = d;
            slot_of[h] = i;
        endfunction

        function bit holds(logic [7:0] h);
            return slot_of[h] < held_count && id_at[slot_of[h]] == h;
        endfunction

        function int bubble_up(int i, logic [7:0] h, logic signed [63:0] d);
            int p;
            while (i > 0) begin
                p = (i - 1) / 2;
                if (!(dl_at[p] > d)) break;
                put(i, id_at[p], dl_at[p]);
                i = p;
            end
            put(i, h, d);
            return i;
        endfunction

        function void bubble_down(int i, logic [7:0] h, logic signed [63:0] d);
            int l;
            int c;
            forever begin
                l = 2 * i + 1;
                if (l >= held_count) break;
                c = (l + 1 < held_count && dl_at[l] > dl_at[l + 1]) ? l + 1 : l;
                if (!(d > dl_at[c])) break;
                put(i, id_at[c], dl_at[c]);
                i = c;
            end
            put(i, h, d);
        endfunction

        function void take_out(int pos);
            int last;
            int parent;
            last = held_count - 1;
            held_count = last;
            if (pos == last) return;
            put(pos, id_at[last], dl_at[last]);
            parent = pos > 0 ? (pos - 1) / 2 : 0;
            if (dl_at[parent] > dl_at[pos])
                void'(bubble_up(pos, id_at[pos], dl_at[pos]));
            else
                bubble_down(pos, id_at[pos], dl_at[pos]);
        endfunction

        // note an accepted request beat and queue its expected result
        function void note_request(req_t req, logic [7:0] h, logic signed [63:0] d);
            heap_result_t r;
            r.status = STS_OK;
            r.became_top = 1'b0;
            case (req)
                REQ_ADD: begin
                    if (holds(h)) r.status = STS_BAD_HNDL;
                    else if (held_count >= HEAP_CAP) r.status = STS_FULL;
                    else begin
                        held_count++;
                        r.became_top = (bubble_up(held_count - 1, h, d) == 0);
                    end
                end
                REQ_REMOVE: begin
                    if (holds(h)) take_out(slot_of[h]);
                    else r.status = STS_BAD_HNDL;
                end
                REQ_POP: begin
                    if (held_count == 0) r.status = STS_EMPTY;
                    else take_out(0);
                end
                default: ;
            endcase
            r.is_empty = (held_count == 0);
            r.top_id = held_count == 0 ? 8'd0 : id_at[0];
            r.top_deadline = held_count == 0 ? 64'sd0 : dl_at[0];
            r.count = held_count[8:0];
            pending_results.push_back(r);
        endfunction

        // compare one result beat with the oldest expectation
        function void check_result(logic [OUT_W-1:0] data);
            heap_result_t e;
            bit bad;
            results_seen++;
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat %h", data);
                return;
            end
            e = pending_results.pop_front();
            bad = data[1:0] != e.status || data[2] != e.became_top ||
                  data[3] != e.is_empty || data[11:4] != e.top_id ||
                  data[75:12] != e.top_deadline || data[84:76] != e.count;
            if (bad) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("result mismatch: exp sts %0d top %0b empty %0b id %0d dl %0d cnt %0d",
                             e.status, e.became_top, e.is_empty, e.top_id,
                             e.top_deadline, e.count);
                    $display("                 got sts %0d top %0b empty %0b id %0d dl %0d cnt %0d",
                             data[1:0], data[2], data[3], data[11:4],
                             $signed(data[75:12]), data[84:76]);
                end
            end
        endfunction
    endclass

    logic              aclk;
    logic              aresetn;
    logic              s_tvalid;
    logic              s_tready;
    logic [IN_W-1:0]   s_tdata;
    logic              m_tvalid;
    logic              m_tready;
    logic [OUT_W-1:0]  m_tdata;

    heap_tracker       tracker;
    bit                idling_on;
    bit                hold_off_req;
    bit                ever_added [NUM_HANDLES];
    int                requests_sent;
    int                full_hits;

    timer_deadline_min_heap_top u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial aclk = 1'b0;
    always #1 aclk = ~aclk;

    // offer one request beat, wait for the handshake, then log it
    task automatic send_request(req_t req, logic [7:0] h, logic signed [63:0] d);
        bit taken;
        if (idling_on && $urandom_range(99) < 26) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'b0, d, h, req};
        do begin
            @(negedge aclk);
            taken = s_tready;
            @(posedge aclk);
        end while (!taken);
        if (req == REQ_ADD && !tracker.holds(h) && tracker.held_count >= HEAP_CAP)
            full_hits++;
        tracker.note_request(req, h, d);
        if (req == REQ_ADD) ever_added[h] = 1'b1;
        requests_sent++;
    endtask

    function automatic logic signed [63:0] pick_deadline();
        case ($urandom_range(9))
            0: return 64'sh8000000000000000;
            1: return 64'sh7fffffffffffffff;
            2, 3, 4: return {$urandom, $urandom};
            default: return $signed(64'($urandom_range(15))) - 64'sd8;
        endcase
    endfunction

    // handle that was added at some point but is not held now, if any
    function automatic int stale_handle();
        int start;
        int h;
        start = int'($urandom_range(255));
        for (int k = 0; k < NUM_HANDLES; k++) begin
            h = (start + k) % NUM_HANDLES;
            if (ever_added[h] && !tracker.holds(8'(h))) return h;
        end
        return -1;
    endfunction

    // handle that is not held now, or -1 when every handle is held
    function automatic int free_handle();
        int start;
        int h;
        start = int'($urandom_range(255));
        for (int k = 0; k < NUM_HANDLES; k++) begin
            h = (start + k) % NUM_HANDLES;
            if (!tracker.holds(8'(h))) return h;
        end
        return -1;
    endfunction

    // one random request; add_bias is the percentage of adds
    task automatic random_request(int add_bias);
        int roll;
        int h;
        roll = int'($urandom_range(99));
        if (roll < add_bias) begin
            if ($urandom_range(9) == 0 && tracker.held_count > 0)
                h = int'(tracker.id_at[$urandom_range(tracker.held_count - 1)]);
            else
                h = int'($urandom_range(255));
            send_request(REQ_ADD, 8'(h), pick_deadline());
        end else if (roll < add_bias + (100 - add_bias) / 2) begin
            h = -1;
            if ($urandom_range(4) == 0) h = stale_handle();
            if (h < 0 && tracker.held_count > 0)
                h = int'(tracker.id_at[$urandom_range(tracker.held_count - 1)]);
            if (h < 0) send_request(REQ_POP, 8'($urandom_range(255)), pick_deadline());
            else send_request(REQ_REMOVE, 8'(h), pick_deadline());
        end else if (roll < 97) begin
            send_request(REQ_POP, 8'($urandom_range(255)), pick_deadline());
        end else begin
            send_request(REQ_NONE, 8'($urandom_range(255)), pick_deadline());
        end
    endtask

    // result side: random back-pressure plus one long hold-off on request
    initial begin
        int hold_left;
        hold_left = 0;
        m_tready = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                hold_left = 400;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= !(idling_on && $urandom_range(99) < 26);
            end
            @(negedge aclk);
            if (aresetn && m_tvalid && m_tready) tracker.check_result(m_tdata);
        end
    end

    initial begin
        #2_000_000;
        $display("timer_deadline_min_heap_top_test: done, errors");
        $finish;
    end

    initial begin
        int drain_wait;
        tracker = new();
        idling_on = 1'b1;
        hold_off_req = 1'b0;
        requests_sent = 0;
        full_hits = 0;
        foreach (ever_added[i]) ever_added[i] = 1'b0;
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: empty pop, extreme deadlines, ties, duplicates, stale handle
        send_request(REQ_POP, 8'd0, 64'sd0);
        send_request(REQ_NONE, 8'hff, 64'sh7fffffffffffffff);
        send_request(REQ_ADD, 8'd5, 64'sd100);
        send_request(REQ_ADD, 8'd255, 64'sh7fffffffffffffff);
        send_request(REQ_ADD, 8'd0, 64'sh8000000000000000);
        send_request(REQ_ADD, 8'd7, 64'sh8000000000000000);
        send_request(REQ_ADD, 8'd5, 64'sd1);
        send_request(REQ_ADD, 8'd9, 64'sd100);
        send_request(REQ_ADD, 8'd10, -64'sd1);
        send_request(REQ_REMOVE, 8'd255, 64'sd0);
        send_request(REQ_REMOVE, 8'd255, 64'sd0);
        send_request(REQ_REMOVE, 8'd0, 64'sd0);
        send_request(REQ_NONE, 8'd3, -64'sd1);
        send_request(REQ_POP, 8'd9, 64'sd0);
        send_request(REQ_ADD, 8'd255, 64'sd0);
        send_request(REQ_REMOVE, 8'd5, 64'sd0);
        send_request(REQ_POP, 8'd0, 64'sd0);
        send_request(REQ_POP, 8'd0, 64'sd0);
        send_request(REQ_POP, 8'd0, 64'sd0);
        send_request(REQ_POP, 8'd0, 64'sd0);
        send_request(REQ_REMOVE, 8'd10, 64'sd0);

        // balanced mix with a stretch of no idling on either side
        for (int n = 0; n < 400; n++) begin
            idling_on = !(n >= 150 && n < 300);
            random_request(45);
        end

        // sender pauses until all results are back
        s_tvalid <= 1'b0;
        while (tracker.pending_results.size() != 0) @(posedge aclk);

        // fill to capacity, mostly with free handles, starting under a long receiver stall
        hold_off_req = 1'b1;
        while (tracker.held_count < HEAP_CAP) begin
            if ($urandom_range(9) == 0) random_request(50);
            else send_request(REQ_ADD, 8'(free_handle()), pick_deadline());
        end
        for (int n = 0; n < 30; n++) random_request(70);

        // drain and mixed traffic near and below capacity
        for (int n = 0; n < 300; n++) random_request(25);
        while (requests_sent < 1400) random_request(50);
        while (tracker.held_count > 0) random_request(0);
        send_request(REQ_POP, 8'd0, 64'sd0);

        s_tvalid <= 1'b0;
        while (tracker.pending_results.size() != 0) @(posedge aclk);
        drain_wait = 60;
        repeat (drain_wait) @(posedge aclk);

        $display("covered %0d requests, %0d result beats, %0d adds refused as full",
                 requests_sent, tracker.results_seen, full_hits);
        if (tracker.mismatches == 0 && tracker.pending_results.size() == 0) begin
            $display("timer_deadline_min_heap_top_test: done, clean");
        end else begin
            $display("%0d mismatches, %0d results missing", tracker.mismatches,
                     tracker.pending_results.size());
            $display("timer_deadline_min_heap_top_test: done, errors");
        end
        $finish;
    end
endmodule

>>> sim.f
design/tdmh_pkg.sv
design/timer_deadline_min_heap_top.sv
verif/timer_deadline_min_heap_top_test.sv
